/* rtl/bpcq_pkg.sv */
// Shared types, codes and defaults for the button press classifier queue.
`timescale 1ns / 1ps

package bpcq_pkg;

   localparam int DEF_QUEUE_SLOTS  = 16;
   localparam int DEF_BUTTON_COUNT = 7;

   localparam int EDGE_W  = 7;
   localparam int STAMP_W = 32;
   localparam int LIMIT_W = 16;
   localparam int COUNT_W = 4;
   localparam int DROP_W  = 3;

   localparam logic [LIMIT_W-1:0] LONG_PRESS_RESET    = 16'd500;
   localparam logic [LIMIT_W-1:0] DOUBLE_WINDOW_RESET = 16'd300;
   localparam logic [EDGE_W-1:0]  DOUBLE_MASK_RESET   = 7'd0;

   typedef enum logic [1:0] {
      ACT_UPDATE  = 2'd0,
      ACT_CONSUME = 2'd1,
      ACT_DRAIN   = 2'd2,
      ACT_FRONT   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      REG_LONG_PRESS    = 2'd0,
      REG_DOUBLE_WINDOW = 2'd1,
      REG_DOUBLE_MASK   = 2'd2,
      REG_UNUSED        = 2'd3
   } reg_index_type;

   localparam logic [1:0] PH_IDLE           = 2'd0;
   localparam logic [1:0] PH_PRESSED        = 2'd1;
   localparam logic [1:0] PH_RELEASED_ONCE  = 2'd2;
   localparam logic [1:0] PH_DOUBLE_PRESSED = 2'd3;

   localparam logic [1:0] KIND_SHORT  = 2'd0;
   localparam logic [1:0] KIND_LONG   = 2'd1;
   localparam logic [1:0] KIND_DOUBLE = 2'd2;

   typedef struct packed {
      logic [1:0]         phase;
      logic [STAMP_W-1:0] press;
      logic [STAMP_W-1:0] release_t;
   } btn_state_type;

   typedef struct packed {
      logic [2:0] button;
      logic [1:0] kind;
   } event_type;

   typedef struct packed {
      logic      push_back;
      logic      push_front;
      logic      pop;
      logic      clear;
      event_type entry;
   } ring_cmd_type;

   typedef struct packed {
      logic full_back;
      logic full_front;
      logic empty;
   } ring_status_type;

endpackage

/* rtl/button_press_classifier_queue_core.sv */
// Top level: item sequencer, per-button classifier and result register.
`timescale 1ns / 1ps

// An update item reads and rewrites each button's state entry in turn, one
// button per cycle with the next read overlapped, and then loads the result
// register in S_DONE; consume, drain and push-front pass through their own
// action state and then S_DONE. The next item is taken once the sequencer is
// back in S_IDLE. The per-button memory read is prefetched and the ring has a
// single write port. One item is in flight at a time; a new item is taken while
// the previous result still waits on rsp_tready.
module button_press_classifier_queue_core #(
   parameter int QUEUE_SLOTS  = bpcq_pkg::DEF_QUEUE_SLOTS,
   parameter int BUTTON_COUNT = bpcq_pkg::DEF_BUTTON_COUNT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // now_ms[31:0], pressed_edges[38:32], released_edges[45:39],
   // held_levels[52:46], front_button[55:53], front_kind[57:56], zero fill
   input  logic [63:0] req_tdata,
   // action[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // event_button[2:0], event_kind[4:3], queue_count[8:5],
   // dropped_count[11:9], zero fill
   output logic [15:0] rsp_tdata,
   // event_valid[0]
   output logic        rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int BTN_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
   localparam logic [BTN_W-1:0] LAST_BTN = BTN_W'(BUTTON_COUNT - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_UPDATE,
      S_CONSUME,
      S_DRAIN,
      S_FRONT,
      S_DONE
   } state_type;

   state_type state_ff;

   logic [bpcq_pkg::LIMIT_W-1:0] long_ff, window_ff;
   logic [bpcq_pkg::EDGE_W-1:0]  mask_ff;

   logic [bpcq_pkg::STAMP_W-1:0] now_ff;
   logic [15:0]                  press_vec_ff, rel_vec_ff, held_vec_ff;
   logic [2:0]                   front_btn_ff;
   logic [1:0]                   front_kind_ff;

   logic [BTN_W-1:0]             idx_ff;
   logic [bpcq_pkg::DROP_W-1:0]  drops_ff;
   logic                         ev_valid_ff;
   bpcq_pkg::event_type          ev_ff;

   logic                         rsp_valid_ff;
   logic [15:0]                  rsp_data_ff;
   logic                         rsp_user_ff;

   logic                         req_fire;
   logic                         ram_rd_en;
   logic [BTN_W-1:0]             ram_rd_addr;
   bpcq_pkg::btn_state_type      cur, nxt;
   logic                         ram_wr_en;
   logic                         ram_clear;

   bpcq_pkg::ring_cmd_type       ring_cmd;
   bpcq_pkg::ring_status_type    ring_status;
   bpcq_pkg::event_type          ring_head;
   logic [bpcq_pkg::COUNT_W-1:0] ring_count;

   logic                         pr, rel, held, dbl;
   logic [bpcq_pkg::STAMP_W-1:0] hold_time, gap_time;
   logic                         ev_push;
   logic [1:0]                   ev_kind;
   logic                         front_ok;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   bpcq_state_ram #(
      .BUTTON_COUNT(BUTTON_COUNT),
      .ADDR_W      (BTN_W)
   ) u_state_ram (
      .clock  (clock),
      .reset  (reset),
      .clear  (ram_clear),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(cur),
      .wr_en  (ram_wr_en),
      .wr_addr(idx_ff),
      .wr_data(nxt)
   );

   bpcq_event_ring #(
      .QUEUE_SLOTS(QUEUE_SLOTS)
   ) u_event_ring (
      .clock (clock),
      .reset (reset),
      .cmd   (ring_cmd),
      .status(ring_status),
      .head  (ring_head),
      .count (ring_count)
   );

   // Prefetch button 0 on acceptance, then each following button during the walk.
   always_comb begin
      ram_rd_en   = 1'b0;
      ram_rd_addr = '0;
      if (req_fire && (bpcq_pkg::action_type'(req_tuser) == bpcq_pkg::ACT_UPDATE)) begin
         ram_rd_en = 1'b1;
      end else if ((state_ff == S_UPDATE) && (idx_ff != LAST_BTN)) begin
         ram_rd_en   = 1'b1;
         ram_rd_addr = idx_ff + 1'b1;
      end
   end

   assign pr        = press_vec_ff[4'(idx_ff)];
   assign rel       = rel_vec_ff[4'(idx_ff)];
   assign held      = held_vec_ff[4'(idx_ff)];
   assign dbl       = (idx_ff < BTN_W'(bpcq_pkg::EDGE_W)) ? mask_ff[3'(idx_ff)] : 1'b0;
   assign hold_time = now_ff - cur.press;
   assign gap_time  = now_ff - cur.release_t;

   always_comb begin
      nxt     = cur;
      ev_push = 1'b0;
      ev_kind = bpcq_pkg::KIND_SHORT;
      case (cur.phase)
         bpcq_pkg::PH_IDLE: begin
            if (pr) begin
               nxt.phase = bpcq_pkg::PH_PRESSED;
               nxt.press = now_ff;
            end
         end
         bpcq_pkg::PH_PRESSED: begin
            if (rel) begin
               if (hold_time >= 32'(long_ff)) begin
                  ev_push   = 1'b1;
                  ev_kind   = bpcq_pkg::KIND_LONG;
                  nxt.phase = bpcq_pkg::PH_IDLE;
               end else if (dbl) begin
                  nxt.release_t = now_ff;
                  nxt.phase     = bpcq_pkg::PH_RELEASED_ONCE;
               end else begin
                  ev_push   = 1'b1;
                  nxt.phase = bpcq_pkg::PH_IDLE;
               end
            end else if (!held) begin
               nxt.phase = bpcq_pkg::PH_IDLE;
            end
         end
         bpcq_pkg::PH_RELEASED_ONCE: begin
            if (pr) begin
               nxt.phase = bpcq_pkg::PH_DOUBLE_PRESSED;
               nxt.press = now_ff;
            end else if (gap_time >= 32'(window_ff)) begin
               ev_push   = 1'b1;
               nxt.phase = bpcq_pkg::PH_IDLE;
            end
         end
         default: begin
            if (rel || !held) begin
               ev_push   = 1'b1;
               ev_kind   = bpcq_pkg::KIND_DOUBLE;
               nxt.phase = bpcq_pkg::PH_IDLE;
            end
         end
      endcase
   end

   assign ram_wr_en = (state_ff == S_UPDATE);
   assign ram_clear = (state_ff == S_DRAIN);
   assign front_ok  = (front_kind_ff <= bpcq_pkg::KIND_DOUBLE) &&
                      (5'(front_btn_ff) < 5'(BUTTON_COUNT));

   always_comb begin
      ring_cmd = '0;
      case (state_ff)
         S_UPDATE: begin
            ring_cmd.push_back    = ev_push;
            ring_cmd.entry.button = 3'(idx_ff);
            ring_cmd.entry.kind   = ev_kind;
         end
         S_CONSUME: begin
            ring_cmd.pop = 1'b1;
         end
         S_DRAIN: begin
            ring_cmd.clear = 1'b1;
         end
         S_FRONT: begin
            ring_cmd.push_front   = front_ok;
            ring_cmd.entry.button = front_btn_ff;
            ring_cmd.entry.kind   = front_kind_ff;
         end
         default: begin
            ring_cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_ff   <= bpcq_pkg::LONG_PRESS_RESET;
         window_ff <= bpcq_pkg::DOUBLE_WINDOW_RESET;
         mask_ff   <= bpcq_pkg::DOUBLE_MASK_RESET;
      end else if (csr_valid && csr_ready) begin
         case (bpcq_pkg::reg_index_type'(csr_index))
            bpcq_pkg::REG_LONG_PRESS:    long_ff   <= csr_data;
            bpcq_pkg::REG_DOUBLE_WINDOW: window_ff <= csr_data;
            bpcq_pkg::REG_DOUBLE_MASK:   mask_ff   <= csr_data[bpcq_pkg::EDGE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         now_ff        <= req_tdata[31:0];
         press_vec_ff  <= {9'd0, req_tdata[38:32]};
         rel_vec_ff    <= {9'd0, req_tdata[45:39]};
         held_vec_ff   <= {9'd0, req_tdata[52:46]};
         front_btn_ff  <= req_tdata[55:53];
         front_kind_ff <= req_tdata[57:56];
      end
      if (state_ff == S_CONSUME) begin
         ev_ff <= ring_head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         drops_ff     <= '0;
         ev_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= '0;
         rsp_user_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  idx_ff      <= '0;
                  drops_ff    <= '0;
                  ev_valid_ff <= 1'b0;
                  case (bpcq_pkg::action_type'(req_tuser))
                     bpcq_pkg::ACT_UPDATE:  state_ff <= S_UPDATE;
                     bpcq_pkg::ACT_CONSUME: state_ff <= S_CONSUME;
                     bpcq_pkg::ACT_DRAIN:   state_ff <= S_DRAIN;
                     default:               state_ff <= S_FRONT;
                  endcase
               end
            end
            S_UPDATE: begin
               if (ev_push && ring_status.full_back) begin
                  drops_ff <= drops_ff + 1'b1;
               end
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == LAST_BTN) begin
                  state_ff <= S_DONE;
               end
            end
            S_CONSUME: begin
               ev_valid_ff <= !ring_status.empty;
               state_ff    <= S_DONE;
            end
            S_DRAIN: begin
               state_ff <= S_DONE;
            end
            S_FRONT: begin
               if (front_ok && ring_status.full_front) begin
                  drops_ff <= drops_ff + 1'b1;
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_user_ff  <= ev_valid_ff;
                  rsp_data_ff  <= {4'd0, drops_ff, ring_count,
                                   ev_valid_ff ? ev_ff.kind : 2'd0,
                                   ev_valid_ff ? ev_ff.button : 3'd0};
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

/* rtl/bpcq_state_ram.sv */
// Per-button phase and timestamp memory with reset-valid flags.
`timescale 1ns / 1ps

module bpcq_state_ram #(
   parameter int BUTTON_COUNT = bpcq_pkg::DEF_BUTTON_COUNT,
   parameter int ADDR_W       = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    clear,
   input  logic                    rd_en,
   input  logic [ADDR_W-1:0]       rd_addr,
   output bpcq_pkg::btn_state_type rd_data,
   input  logic                    wr_en,
   input  logic [ADDR_W-1:0]       wr_addr,
   input  bpcq_pkg::btn_state_type wr_data
);

   bpcq_pkg::btn_state_type btn_mem [BUTTON_COUNT];
   logic [BUTTON_COUNT-1:0] valid_ff;
   bpcq_pkg::btn_state_type rd_data_ff;
   logic                    rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         btn_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= btn_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

/* rtl/bpcq_event_ring.sv */
// Event ring memory with back and front push, pop, drain and occupancy.
`timescale 1ns / 1ps

module bpcq_event_ring #(
   parameter int QUEUE_SLOTS = bpcq_pkg::DEF_QUEUE_SLOTS,
   parameter int PTR_W       = $clog2(QUEUE_SLOTS)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  bpcq_pkg::ring_cmd_type          cmd,
   output bpcq_pkg::ring_status_type       status,
   output bpcq_pkg::event_type             head,
   output logic [bpcq_pkg::COUNT_W-1:0]    count
);

   localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_SLOTS - 1);

   bpcq_pkg::event_type ev_mem [QUEUE_SLOTS];
   bpcq_pkg::event_type head_ff;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    wr_next, rd_prev, rd_next;
   logic [PTR_W-1:0]    occupancy;
   logic                do_back, do_front;

   assign wr_next = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_next = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
   assign rd_prev = (rd_ptr_ff == '0) ? LAST : rd_ptr_ff - 1'b1;

   assign status.full_back  = (wr_next == rd_ptr_ff);
   assign status.full_front = (rd_prev == wr_ptr_ff);
   assign status.empty      = (rd_ptr_ff == wr_ptr_ff);

   assign do_back  = cmd.push_back && !status.full_back;
   assign do_front = cmd.push_front && !status.full_front;

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      if (cmd.clear) begin
         rd_ptr_in = '0;
         wr_ptr_in = '0;
      end else if (do_back) begin
         wr_ptr_in = wr_next;
      end else if (do_front) begin
         rd_ptr_in = rd_prev;
      end else if (cmd.pop && !status.empty) begin
         rd_ptr_in = rd_next;
      end
   end

   always_comb begin
      if (wr_ptr_ff >= rd_ptr_ff) begin
         occupancy = wr_ptr_ff - rd_ptr_ff;
      end else begin
         occupancy = PTR_W'(QUEUE_SLOTS - int'(rd_ptr_ff) + int'(wr_ptr_ff));
      end
   end

   assign count = bpcq_pkg::COUNT_W'(occupancy);
   assign head  = head_ff;

   always_ff @(posedge clock) begin
      if (do_back && !cmd.clear) begin
         ev_mem[wr_ptr_ff] <= cmd.entry;
      end else if (do_front && !cmd.clear) begin
         ev_mem[rd_prev] <= cmd.entry;
      end
      head_ff <= ev_mem[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

endmodule

/* rtl/bpcq_checker.sv */
// Port-level checks on the classifier queue core, bound to the top level.
`timescale 1ns / 1ps

module bpcq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second transaction taken while one is in progress");

   a_empty_event_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[4:0] == 5'd0)
      else $error("event fields nonzero without an event");

   a_drop_no_event: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[11:9] != 3'd0) |-> !rsp_tuser)
      else $error("drops reported together with a consumed event");

endmodule

bind button_press_classifier_queue_core bpcq_checker u_bpcq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);
